@@ rtl/core/pllm_pkg.sv @@
// shared constants, types and helpers for the pooled linked list manager
`timescale 1ns / 1ps
package pllm_pkg;

    localparam int NUM_LISTS = 16;
    localparam int NUM_NODES = 256;
    localparam int ITEM_BITS = 32;

    localparam int NAW = $clog2(NUM_NODES);       // node address bits
    localparam int NW  = $clog2(NUM_NODES + 1);   // node index with null
    localparam int LIW = $clog2(NUM_LISTS);       // list address bits
    localparam int LW  = $clog2(NUM_LISTS + 1);   // list index with null

    localparam int KW  = 4;
    localparam int SW  = 2;
    localparam int PW  = 2;

    localparam int IN_BITS  = KW + LIW + LIW + ITEM_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = SW + ITEM_BITS + LIW + NW;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_W - OUT_BITS;

    typedef logic [NW-1:0]        t_node;
    typedef logic [LIW-1:0]       t_lidx;
    typedef logic [LW-1:0]        t_lcnt;
    typedef logic [ITEM_BITS-1:0] t_item;
    typedef logic [KW-1:0]        t_kind;
    typedef logic [SW-1:0]        t_stat;
    typedef logic [PW-1:0]        t_place;

    localparam t_node NIL_NODE = t_node'(NUM_NODES);
    localparam t_lcnt NIL_LIST = t_lcnt'(NUM_LISTS);

    localparam t_kind K_CREATE  = 4'd0;
    localparam t_kind K_COUNT   = 4'd1;
    localparam t_kind K_FIRST   = 4'd2;
    localparam t_kind K_LAST    = 4'd3;
    localparam t_kind K_NEXT    = 4'd4;
    localparam t_kind K_PREV    = 4'd5;
    localparam t_kind K_CURR    = 4'd6;
    localparam t_kind K_ADD     = 4'd7;
    localparam t_kind K_INSERT  = 4'd8;
    localparam t_kind K_APPEND  = 4'd9;
    localparam t_kind K_PREPEND = 4'd10;
    localparam t_kind K_REMOVE  = 4'd11;
    localparam t_kind K_TRIM    = 4'd12;
    localparam t_kind K_CONCAT  = 4'd13;
    localparam t_kind K_FREE    = 4'd14;

    localparam t_stat ST_OK      = 2'd0;
    localparam t_stat ST_NONE    = 2'd1;
    localparam t_stat ST_INVALID = 2'd2;
    localparam t_stat ST_FULL    = 2'd3;

    localparam t_place P_WITHIN = 2'd0;
    localparam t_place P_BEFORE = 2'd1;
    localparam t_place P_BEYOND = 2'd2;

    function automatic logic node_ok(input t_node n);
        return n < NIL_NODE;
    endfunction

endpackage

@@ rtl/core/pllm_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module pllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pooled_linked_list_manager.sv @@
// pooled linked list manager: list table, free stacks and operation sequencer
// throughput: one request at a time, set by the sequencer and the single
// read port of each node memory; the next request is taken once a result is queued
// reset: synchronous active low; a clearing pass then chains the node pool,
// and no request is taken during it
`timescale 1ns / 1ps
module pooled_linked_list_manager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // kind, list_id, second_list_id, item_handle
    input  logic [pllm_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // status, item_out, new_list, count_out
    output logic [pllm_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready
);
    import pllm_pkg::*;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_EXEC = 5'd2;
    localparam logic [4:0] S_VAL  = 5'd3;
    localparam logic [4:0] S_NAV  = 5'd4;
    localparam logic [4:0] S_POP  = 5'd5;
    localparam logic [4:0] S_PRV  = 5'd6;
    localparam logic [4:0] S_LNK  = 5'd7;
    localparam logic [4:0] S_W1   = 5'd8;
    localparam logic [4:0] S_W2   = 5'd9;
    localparam logic [4:0] S_UL2  = 5'd10;
    localparam logic [4:0] S_UL3  = 5'd11;
    localparam logic [4:0] S_C1   = 5'd12;
    localparam logic [4:0] S_C2   = 5'd13;
    localparam logic [4:0] S_C3   = 5'd14;
    localparam logic [4:0] S_F1   = 5'd15;
    localparam logic [4:0] S_F2   = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;

    logic [4:0] r_state, n_state;
    logic [NAW-1:0] r_clr;

    // list table
    t_node  r_first [NUM_LISTS];
    t_node  r_last  [NUM_LISTS];
    t_node  r_cur   [NUM_LISTS];
    t_place r_place [NUM_LISTS];
    t_node  r_len   [NUM_LISTS];
    logic   r_use   [NUM_LISTS];

    t_node r_ftop, n_ftop, r_fcnt, n_fcnt;
    t_lcnt r_htop, n_htop, r_hcnt, n_hcnt;

    // request and working registers
    t_kind r_kind;
    t_lidx r_l, r_l2;
    t_item r_item;
    t_node r_n, n_n, r_a, n_a, r_b, n_b, r_c, n_c, r_len2, n_len2;
    t_stat r_st, n_st;
    t_item r_iout, n_iout;
    t_lidx r_newl, n_newl;
    t_node r_cnt, n_cnt;

    // output register
    logic  r_ovalid;
    t_stat r_ost;
    t_item r_oitem;
    t_lidx r_onewl;
    t_node r_ocnt;

    // node memories
    logic nx_we, pv_we, vl_we;
    logic [NAW-1:0] nx_wa, nx_ra, pv_wa, pv_ra, vl_wa, vl_ra;
    t_node nx_wd, nx_rd, pv_wd, pv_rd;
    t_item vl_wd, vl_rd;

    // list table write port
    t_lidx  w_li;
    logic   lw_first, lw_last, lw_cur, lw_place, lw_len, lw_use;
    t_node  lv_first, lv_last, lv_cur, lv_len;
    t_place lv_place;
    logic   lv_use;

    t_node  w_first, w_last, w_cur, w_len, w_nb;
    t_place w_place;
    logic   w_use, w_fwd, w_acc;

    pllm_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd)
    );
    pllm_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd)
    );
    pllm_ram #(.WIDTH(ITEM_BITS), .DEPTH(NUM_NODES)) u_value (
        .i_clk(i_clk), .i_we(vl_we), .i_waddr(vl_wa), .i_wdata(vl_wd),
        .i_raddr(vl_ra), .o_rdata(vl_rd)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // concat reads and releases the second list in its own cycles
    assign w_li    = (r_state == S_C1 || r_state == S_C3) ? r_l2 : r_l;
    assign w_first = r_first[w_li];
    assign w_last  = r_last[w_li];
    assign w_cur   = r_cur[w_li];
    assign w_place = r_place[w_li];
    assign w_len   = r_len[w_li];
    assign w_use   = r_use[w_li];
    assign w_fwd   = (r_kind == K_NEXT);

    always_comb begin
        n_state = r_state;
        n_ftop = r_ftop;   n_fcnt = r_fcnt;
        n_htop = r_htop;   n_hcnt = r_hcnt;
        n_n = r_n; n_a = r_a; n_b = r_b; n_c = r_c; n_len2 = r_len2;
        n_st = r_st; n_iout = r_iout; n_newl = r_newl; n_cnt = r_cnt;
        nx_we = 1'b0; nx_wa = r_n[NAW-1:0]; nx_wd = r_b; nx_ra = r_n[NAW-1:0];
        pv_we = 1'b0; pv_wa = r_n[NAW-1:0]; pv_wd = r_a; pv_ra = r_n[NAW-1:0];
        vl_we = 1'b0; vl_wa = r_n[NAW-1:0]; vl_wd = r_item; vl_ra = r_n[NAW-1:0];
        lw_first = 1'b0; lv_first = NIL_NODE;
        lw_last  = 1'b0; lv_last  = NIL_NODE;
        lw_cur   = 1'b0; lv_cur   = NIL_NODE;
        lw_place = 1'b0; lv_place = P_WITHIN;
        lw_len   = 1'b0; lv_len   = '0;
        lw_use   = 1'b0; lv_use   = 1'b0;
        w_nb = NIL_NODE;

        case (r_state)
            S_CLR: begin
                nx_we = 1'b1;
                nx_wa = r_clr;
                nx_wd = t_node'({1'b0, r_clr}) + t_node'(1);
                if (r_clr == NAW'(NUM_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                    n_iout  = '0;
                    n_newl  = '0;
                    n_cnt   = '0;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_st    = ST_INVALID;
                if (r_kind == K_CREATE) begin
                    if (r_hcnt == '0 || r_htop >= NIL_LIST) begin
                        n_st = ST_FULL;
                    end else begin
                        n_newl = r_l;
                        n_htop = (w_first > t_node'(NUM_LISTS)) ? NIL_LIST
                                                                : w_first[LW-1:0];
                        n_hcnt = r_hcnt - t_lcnt'(1);
                        lw_use = 1'b1; lv_use = 1'b1;
                        lw_first = 1'b1; lw_last = 1'b1; lw_cur = 1'b1;
                        lw_place = 1'b1; lw_len = 1'b1;
                        n_st = ST_OK;
                    end
                end else if (!w_use) begin
                    n_st = ST_INVALID;
                end else begin
                    case (r_kind)
                        K_COUNT: begin
                            n_cnt = w_len;
                            n_st  = ST_OK;
                        end
                        K_FIRST, K_LAST, K_NEXT, K_PREV: begin
                            if ((r_kind == K_NEXT && w_place == P_BEYOND) ||
                                (r_kind == K_PREV && w_place == P_BEFORE)) begin
                                n_st = ST_NONE;
                            end else if (r_kind == K_FIRST || r_kind == K_LAST ||
                                         (r_kind == K_NEXT && w_place == P_BEFORE) ||
                                         (r_kind == K_PREV && w_place == P_BEYOND)) begin
                                // jump to an end of the list
                                lw_cur = 1'b1;
                                lv_cur = (r_kind == K_LAST || r_kind == K_PREV)
                                         ? w_last : w_first;
                                vl_ra  = lv_cur[NAW-1:0];
                                if (!node_ok(lv_cur)) begin
                                    n_st = ST_NONE;
                                end else begin
                                    lw_place = 1'b1; lv_place = P_WITHIN;
                                    n_state  = S_VAL;
                                end
                            end else if (!node_ok(w_cur)) begin
                                n_st = ST_NONE;
                            end else begin
                                nx_ra   = w_cur[NAW-1:0];
                                pv_ra   = w_cur[NAW-1:0];
                                n_state = S_NAV;
                            end
                        end
                        K_CURR: begin
                            vl_ra = w_cur[NAW-1:0];
                            if (node_ok(w_cur)) begin
                                n_state = S_VAL;
                            end else begin
                                n_st = ST_NONE;
                            end
                        end
                        K_ADD, K_INSERT, K_APPEND, K_PREPEND: begin
                            nx_ra = r_ftop[NAW-1:0];
                            n_n   = r_ftop;
                            if (r_fcnt == '0 || !node_ok(r_ftop)) begin
                                n_st = ST_FULL;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        K_REMOVE, K_TRIM: begin
                            n_c = (r_kind == K_TRIM) ? w_last : w_cur;
                            nx_ra = n_c[NAW-1:0];
                            pv_ra = n_c[NAW-1:0];
                            vl_ra = n_c[NAW-1:0];
                            if (r_kind == K_TRIM ? !node_ok(w_last)
                                : (w_place != P_WITHIN || !node_ok(w_cur))) begin
                                n_st = ST_NONE;
                            end else begin
                                n_state = S_UL2;
                            end
                        end
                        K_CONCAT: begin
                            n_state = S_C1;
                        end
                        K_FREE: begin
                            n_n     = w_first;
                            n_state = S_F1;
                        end
                        default: begin
                            n_st = ST_INVALID;
                        end
                    endcase
                end
            end
            S_VAL: begin
                n_iout  = vl_rd;
                n_st    = ST_OK;
                n_state = S_DONE;
            end
            S_NAV: begin
                lw_cur = 1'b1;
                lv_cur = w_fwd ? nx_rd : pv_rd;
                vl_ra  = lv_cur[NAW-1:0];
                if (node_ok(lv_cur)) begin
                    n_state = S_VAL;
                end else begin
                    lw_place = 1'b1;
                    lv_place = w_fwd ? P_BEYOND : P_BEFORE;
                    n_st     = ST_NONE;
                    n_state  = S_DONE;
                end
            end
            S_POP: begin
                n_ftop = nx_rd;
                n_fcnt = r_fcnt - t_node'(1);
                vl_we  = 1'b1;
                lw_len = 1'b1; lv_len = w_len + t_node'(1);
                n_state = S_LNK;
                pv_ra   = w_cur[NAW-1:0];
                if (!node_ok(w_first) || r_kind == K_PREPEND) begin
                    n_a = NIL_NODE;
                end else if (r_kind == K_APPEND) begin
                    n_a = w_last;
                end else if (w_place == P_BEFORE) begin
                    n_a = NIL_NODE;
                end else if (w_place == P_WITHIN && node_ok(w_cur)) begin
                    n_a = w_cur;
                    if (r_kind == K_INSERT) begin
                        n_state = S_PRV;
                    end
                end else begin
                    n_a = w_last;
                end
            end
            S_PRV: begin
                n_a     = pv_rd;
                n_state = S_LNK;
            end
            S_LNK: begin
                nx_ra   = r_a[NAW-1:0];
                n_state = S_W1;
            end
            S_W1: begin
                w_nb  = node_ok(r_a) ? nx_rd : w_first;
                n_b   = w_nb;
                nx_we = 1'b1; nx_wa = r_n[NAW-1:0]; nx_wd = w_nb;
                pv_we = 1'b1; pv_wa = r_n[NAW-1:0]; pv_wd = r_a;
                n_state = S_W2;
            end
            S_W2: begin
                if (node_ok(r_a)) begin
                    nx_we = 1'b1; nx_wa = r_a[NAW-1:0]; nx_wd = r_n;
                end else begin
                    lw_first = 1'b1; lv_first = r_n;
                end
                if (node_ok(r_b)) begin
                    pv_we = 1'b1; pv_wa = r_b[NAW-1:0]; pv_wd = r_n;
                end else begin
                    lw_last = 1'b1; lv_last = r_n;
                end
                lw_cur = 1'b1; lv_cur = r_n;
                lw_place = 1'b1; lv_place = P_WITHIN;
                n_st    = ST_OK;
                n_state = S_DONE;
            end
            S_UL2: begin
                // unlink the node in r_c: pv_rd is its predecessor, nx_rd its successor
                n_iout   = vl_rd;
                lw_place = 1'b1;
                if (node_ok(nx_rd)) begin
                    pv_we = 1'b1; pv_wa = nx_rd[NAW-1:0]; pv_wd = pv_rd;
                    lv_place = P_WITHIN;
                end else begin
                    lw_last = 1'b1; lv_last = pv_rd;
                    lv_place = P_BEYOND;
                end
                if (node_ok(pv_rd)) begin
                    nx_we = 1'b1; nx_wa = pv_rd[NAW-1:0]; nx_wd = nx_rd;
                end else begin
                    lw_first = 1'b1; lv_first = nx_rd;
                end
                lw_cur = 1'b1; lv_cur = nx_rd;
                lw_len = 1'b1; lv_len = w_len - t_node'(1);
                n_state = S_UL3;
            end
            S_UL3: begin
                nx_we = 1'b1; nx_wa = r_c[NAW-1:0]; nx_wd = r_ftop;
                n_ftop = r_c;
                n_fcnt = r_fcnt + t_node'(1);
                if (r_kind == K_TRIM) begin
                    lw_cur = 1'b1; lv_cur = w_last;
                    if (node_ok(w_last)) begin
                        lw_place = 1'b1; lv_place = P_WITHIN;
                    end
                end
                n_st    = ST_OK;
                n_state = S_DONE;
            end
            S_C1: begin
                n_a = w_first; n_b = w_last; n_len2 = w_len;
                if (!w_use || r_l2 == r_l) begin
                    n_st    = ST_INVALID;
                    n_state = S_DONE;
                end else begin
                    n_state = S_C2;
                end
            end
            S_C2: begin
                if (!node_ok(w_first)) begin
                    lw_first = 1'b1; lv_first = r_a;
                    lw_last  = 1'b1; lv_last  = r_b;
                    lw_len   = 1'b1; lv_len   = r_len2;
                end else if (node_ok(r_a)) begin
                    nx_we = 1'b1; nx_wa = w_last[NAW-1:0]; nx_wd = r_a;
                    pv_we = 1'b1; pv_wa = r_a[NAW-1:0];    pv_wd = w_last;
                    lw_len  = 1'b1; lv_len  = w_len + r_len2;
                    lw_last = 1'b1; lv_last = r_b;
                end
                n_state = S_C3;
            end
            S_C3, S_F1: begin
                nx_ra = r_n[NAW-1:0];
                if (r_state == S_F1 && node_ok(r_n)) begin
                    n_state = S_F2;
                end else begin
                    // release the list head onto the free head stack
                    lw_use   = 1'b1; lv_use = 1'b0;
                    lw_first = 1'b1; lv_first = t_node'(r_htop);
                    lw_last  = 1'b1; lv_last  = NIL_NODE;
                    lw_len   = 1'b1; lv_len   = '0;
                    n_htop   = t_lcnt'(w_li);
                    n_hcnt   = r_hcnt + t_lcnt'(1);
                    n_st     = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_F2: begin
                nx_we = 1'b1; nx_wa = r_n[NAW-1:0]; nx_wd = r_ftop;
                n_ftop  = r_n;
                n_fcnt  = r_fcnt + t_node'(1);
                n_n     = nx_rd;
                n_state = S_F1;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ftop   <= '0;
            r_fcnt   <= t_node'(NUM_NODES);
            r_htop   <= '0;
            r_hcnt   <= t_lcnt'(NUM_LISTS);
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_first[i] <= (i + 1 < NUM_LISTS) ? t_node'(i + 1) : NIL_NODE;
                r_last[i]  <= NIL_NODE;
                r_cur[i]   <= NIL_NODE;
                r_place[i] <= P_WITHIN;
                r_len[i]   <= '0;
                r_use[i]   <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= r_clr + NAW'(1);
            r_ftop  <= n_ftop;
            r_fcnt  <= n_fcnt;
            r_htop  <= n_htop;
            r_hcnt  <= n_hcnt;
            if (lw_first) r_first[w_li] <= lv_first;
            if (lw_last)  r_last[w_li]  <= lv_last;
            if (lw_cur)   r_cur[w_li]   <= lv_cur;
            if (lw_place) r_place[w_li] <= lv_place;
            if (lw_len)   r_len[w_li]   <= lv_len;
            if (lw_use)   r_use[w_li]   <= lv_use;
            if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_a <= n_a; r_b <= n_b; r_c <= n_c; r_len2 <= n_len2;
        r_st <= n_st; r_iout <= n_iout; r_newl <= n_newl; r_cnt <= n_cnt;
        if (w_acc) begin
            r_kind <= i_s_tdata[KW-1:0];
            r_l    <= (i_s_tdata[KW-1:0] == K_CREATE) ? r_htop[LIW-1:0]
                                                      : i_s_tdata[KW+LIW-1:KW];
            r_l2   <= i_s_tdata[KW+2*LIW-1:KW+LIW];
            r_item <= i_s_tdata[IN_BITS-1:KW+2*LIW];
        end
        if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
            r_ost   <= r_st;
            r_oitem <= (r_st == ST_OK) ? r_iout : '0;
            r_onewl <= r_newl;
            r_ocnt  <= r_cnt;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{OUT_PAD{1'b0}}, r_ocnt, r_onewl, r_oitem, r_ost};

endmodule

@@ verif/pooled_linked_list_manager_checker.sv @@
// checker for the pooled linked list manager: predicts each result and compares it
`timescale 1ns / 1ps
module pooled_linked_list_manager_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pllm_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [pllm_pkg::OUT_W-1:0]  i_m_tdata,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    output int                          o_pending,
    output int                          o_errors
);
    import pllm_pkg::*;

    typedef struct packed {
        t_stat   status;
        t_item   item;
        t_lidx   new_list;
        t_node   count;
    } t_result;

    // shadow copy of the pool and list table
    t_item  nval  [NUM_NODES];
    t_node  nnext [NUM_NODES];
    t_node  nprev [NUM_NODES];
    t_node  free_top;
    int     free_cnt;
    t_node  lfirst [NUM_LISTS];
    t_node  llast  [NUM_LISTS];
    t_node  lcur   [NUM_LISTS];
    t_place lplace [NUM_LISTS];
    int     llen   [NUM_LISTS];
    bit     lused  [NUM_LISTS];
    int     head_top;
    int     head_cnt;

    t_result awaited_results[$];

    function automatic bit ok(t_node n);
        return n < NIL_NODE;
    endfunction

    function automatic t_node nx(t_node n);
        return ok(n) ? nnext[n[NAW-1:0]] : NIL_NODE;
    endfunction

    function automatic t_node pv(t_node n);
        return ok(n) ? nprev[n[NAW-1:0]] : NIL_NODE;
    endfunction

    function automatic t_item vl(t_node n);
        return ok(n) ? nval[n[NAW-1:0]] : '0;
    endfunction

    task automatic clear_table();
        for (int i = 0; i < NUM_NODES; i++) begin
            nval[i] = '0;
            nprev[i] = '0;
            nnext[i] = t_node'(i + 1);
        end
        free_top = '0;
        free_cnt = NUM_NODES;
        for (int i = 0; i < NUM_LISTS; i++) begin
            lfirst[i] = (i + 1 < NUM_LISTS) ? t_node'(i + 1) : NIL_NODE;
            llast[i] = NIL_NODE;
            lcur[i] = NIL_NODE;
            lplace[i] = P_WITHIN;
            llen[i] = 0;
            lused[i] = 0;
        end
        head_top = 0;
        head_cnt = NUM_LISTS;
    endtask

    task automatic release_node(t_node n);
        if (ok(n)) begin
            nnext[n[NAW-1:0]] = free_top;
            free_top = n;
            free_cnt++;
        end
    endtask

    task automatic release_list(int l);
        lused[l] = 0;
        lfirst[l] = t_node'(head_top);
        llast[l] = NIL_NODE;
        llen[l] = 0;
        head_top = l;
        head_cnt++;
    endtask

    task automatic link_after(int l, t_node a, t_node n);
        t_node b;
        b = ok(a) ? nx(a) : lfirst[l];
        nprev[n[NAW-1:0]] = a;
        nnext[n[NAW-1:0]] = b;
        if (ok(a)) nnext[a[NAW-1:0]] = n; else lfirst[l] = n;
        if (ok(b)) nprev[b[NAW-1:0]] = n; else llast[l] = n;
        lcur[l] = n;
        lplace[l] = P_WITHIN;
    endtask

    task automatic unlink_cursor(int l, output t_item it);
        t_node c, a, b;
        c = lcur[l];
        a = pv(c);
        b = nx(c);
        it = vl(c);
        if (ok(b)) begin
            nprev[b[NAW-1:0]] = a;
            lplace[l] = P_WITHIN;
        end else begin
            llast[l] = a;
            lplace[l] = P_BEYOND;
        end
        if (ok(a)) nnext[a[NAW-1:0]] = b; else lfirst[l] = b;
        lcur[l] = b;
        release_node(c);
        llen[l]--;
    endtask

    task automatic seek_end(int l, bit to_last, output t_stat st, output t_item it);
        t_node n;
        n = to_last ? llast[l] : lfirst[l];
        lcur[l] = n;
        it = '0;
        if (!ok(n)) begin
            st = ST_NONE;
        end else begin
            lplace[l] = P_WITHIN;
            it = vl(n);
            st = ST_OK;
        end
    endtask

    task automatic apply_request(logic [IN_W-1:0] req, output t_result r);
        t_kind kind;
        int l, l2;
        t_item it_in, it;
        t_stat st;
        t_node n, c, b;
        bit fwd;
        kind = req[KW-1:0];
        l = req[KW +: LIW];
        l2 = req[KW+LIW +: LIW];
        it_in = req[KW+2*LIW +: ITEM_BITS];
        r = '0;
        st = ST_INVALID;
        it = '0;
        if (kind == K_CREATE) begin
            if (head_cnt == 0 || head_top >= NUM_LISTS) begin
                st = ST_FULL;
            end else begin
                r.new_list = t_lidx'(head_top);
                c = lfirst[head_top];
                lused[head_top] = 1;
                lfirst[head_top] = NIL_NODE;
                llast[head_top] = NIL_NODE;
                lcur[head_top] = NIL_NODE;
                lplace[head_top] = P_WITHIN;
                llen[head_top] = 0;
                head_top = (c > NUM_LISTS) ? NUM_LISTS : int'(c);
                head_cnt--;
                st = ST_OK;
            end
        end else if (kind > K_FREE || !lused[l]) begin
            st = ST_INVALID;
        end else if (kind == K_COUNT) begin
            r.count = t_node'(llen[l]);
            st = ST_OK;
        end else if (kind == K_FIRST || kind == K_LAST) begin
            seek_end(l, kind == K_LAST, st, it);
        end else if (kind == K_NEXT || kind == K_PREV) begin
            fwd = (kind == K_NEXT);
            if (lplace[l] == (fwd ? P_BEYOND : P_BEFORE)) st = ST_NONE;
            else if (lplace[l] == (fwd ? P_BEFORE : P_BEYOND)) seek_end(l, !fwd, st, it);
            else if (!ok(lcur[l])) st = ST_NONE;
            else begin
                n = fwd ? nx(lcur[l]) : pv(lcur[l]);
                lcur[l] = n;
                if (ok(n)) begin
                    it = vl(n);
                    st = ST_OK;
                end else begin
                    lplace[l] = fwd ? P_BEYOND : P_BEFORE;
                    st = ST_NONE;
                end
            end
        end else if (kind == K_CURR) begin
            if (ok(lcur[l])) begin
                it = vl(lcur[l]);
                st = ST_OK;
            end else st = ST_NONE;
        end else if (kind >= K_ADD && kind <= K_PREPEND) begin
            if (free_cnt == 0 || !ok(free_top)) begin
                st = ST_FULL;
            end else begin
                n = free_top;
                free_top = nnext[n[NAW-1:0]];
                free_cnt--;
                c = lcur[l];
                nval[n[NAW-1:0]] = it_in;
                llen[l]++;
                if (!ok(lfirst[l]) || kind == K_PREPEND) link_after(l, NIL_NODE, n);
                else if (kind == K_APPEND) link_after(l, llast[l], n);
                else if (lplace[l] == P_BEFORE) link_after(l, NIL_NODE, n);
                else if (lplace[l] == P_WITHIN && ok(c))
                    link_after(l, kind == K_ADD ? c : pv(c), n);
                else link_after(l, llast[l], n);
                st = ST_OK;
            end
        end else if (kind == K_REMOVE) begin
            if (lplace[l] != P_WITHIN || !ok(lcur[l])) st = ST_NONE;
            else begin
                unlink_cursor(l, it);
                st = ST_OK;
            end
        end else if (kind == K_TRIM) begin
            if (!ok(llast[l])) st = ST_NONE;
            else begin
                t_stat dst;
                t_item dit;
                lcur[l] = llast[l];
                lplace[l] = P_WITHIN;
                unlink_cursor(l, it);
                seek_end(l, 1'b1, dst, dit);
                st = ST_OK;
            end
        end else if (kind == K_CONCAT) begin
            if (!lused[l2] || l2 == l) st = ST_INVALID;
            else begin
                if (!ok(lfirst[l])) begin
                    lfirst[l] = lfirst[l2];
                    llast[l] = llast[l2];
                    llen[l] = llen[l2];
                end else if (ok(lfirst[l2])) begin
                    nnext[llast[l][NAW-1:0]] = lfirst[l2];
                    nprev[lfirst[l2][NAW-1:0]] = llast[l];
                    llen[l] += llen[l2];
                    llast[l] = llast[l2];
                end
                release_list(l2);
                st = ST_OK;
            end
        end else begin
            n = lfirst[l];
            for (int i = 0; i < NUM_NODES && ok(n); i++) begin
                b = nnext[n[NAW-1:0]];
                release_node(n);
                n = b;
            end
            release_list(l);
            st = ST_OK;
        end
        if (st != ST_OK) it = '0;
        r.status = st;
        r.item = it;
    endtask

    always @(posedge i_clk) begin
        t_result want, got;
        int errs;
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
            o_errors <= 0;
        end else begin
            errs = 0;
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[OUT_BITS-1:0];
                got.status = i_m_tdata[SW-1:0];
                got.item = i_m_tdata[SW +: ITEM_BITS];
                got.new_list = i_m_tdata[SW+ITEM_BITS +: LIW];
                got.count = i_m_tdata[SW+ITEM_BITS+LIW +: NW];
                if (awaited_results.size() == 0) begin
                    $error("result with nothing expected: %h", i_m_tdata);
                    errs++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.item !== want.item) begin
                        $error("item_out: expected %h, got %h", want.item, got.item);
                        errs++;
                    end
                    if (got.new_list !== want.new_list) begin
                        $error("new_list: expected %0d, got %0d", want.new_list, got.new_list);
                        errs++;
                    end
                    if (got.count !== want.count) begin
                        $error("count_out: expected %0d, got %0d", want.count, got.count);
                        errs++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_request(i_s_tdata, want);
                awaited_results.push_back(want);
            end
            o_errors <= o_errors + errs;
        end
    end

    assign o_pending = awaited_results.size();

endmodule

@@ verif/pooled_linked_list_manager_test.sv @@
// testbench top for the pooled linked list manager: stimulus and verdict
`timescale 1ns / 1ps
module pooled_linked_list_manager_test;
    import pllm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam t_kind K_BAD = 4'd15;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    int               pending;
    int               errors;
    int               cycles = 0;
    bit               drain = 0;

    always #5 i_clk = ~i_clk;

    pooled_linked_list_manager DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    pooled_linked_list_manager_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // receiver stall pattern: long open stretches, then stall phases
    always @(posedge i_clk) begin
        int mode;
        cycles <= cycles + 1;
        mode = (cycles / 600) % 3;
        if (drain || mode == 0) m_tready <= 1'b1;
        else if (mode == 1) m_tready <= ($urandom_range(3, 0) != 0);
        else m_tready <= ($urandom_range(4, 0) == 0);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // holds the request until accepted, then gaps per burst pacing
    int burst_left = 0;
    task automatic send(t_kind k, int l, int l2, t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        s_tdata <= IN_W'({t_item'(it), t_lidx'(l2), t_lidx'(l), k});
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic t_kind pick_kind();
        int r;
        r = $urandom_range(99, 0);
        if (r < 4) return K_CREATE;
        if (r < 30) return t_kind'($urandom_range(6, 1));
        if (r < 62) return t_kind'($urandom_range(10, 7));
        if (r < 80) return t_kind'($urandom_range(12, 11));
        if (r < 85) return K_CONCAT;
        if (r < 87) return K_FREE;
        return K_BAD;
    endfunction

    initial begin
        t_kind k;
        int l, l2;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: invalid lists, empty list corner cases, extremes
        send(K_COUNT, 15, 0, '0);
        send(K_BAD, 0, 0, '0);
        send(K_CREATE, 0, 0, '0);
        send(K_FIRST, 0, 0, '0);
        send(K_LAST, 0, 0, '0);
        send(K_NEXT, 0, 0, '0);
        send(K_REMOVE, 0, 0, '0);
        send(K_TRIM, 0, 0, '0);
        send(K_APPEND, 0, 0, 32'hFFFF_FFFF);
        send(K_PREPEND, 0, 0, 32'h0000_0000);
        send(K_ADD, 0, 0, 32'hA5A5_5A5A);
        send(K_INSERT, 0, 0, 32'h5A5A_A5A5);
        send(K_COUNT, 0, 0, '0);
        send(K_NEXT, 0, 0, '0);
        send(K_NEXT, 0, 0, '0);
        send(K_NEXT, 0, 0, '0);
        send(K_INSERT, 0, 0, 32'h1234_5678);
        send(K_PREV, 0, 0, '0);
        send(K_CURR, 0, 0, '0);
        send(K_CONCAT, 0, 0, '0);
        send(K_CREATE, 0, 0, '0);
        send(K_CONCAT, 1, 0, '0);
        send(K_ADD, 1, 0, 32'h8000_0001);
        send(K_FREE, 1, 0, '0);

        // pause until the block has drained
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        for (int n = 0; n < 540; n++) begin
            // fill the pool once, partway through, to hit exhaustion
            if (n == 400) begin
                for (int j = 0; j < 20; j++) send(K_CREATE, 0, 0, '0);
                for (int j = 0; j < 270; j++)
                    send(K_APPEND, $urandom_range(15, 0), 0, $urandom());
            end
            k = pick_kind();
            l = $urandom_range(15, 0);
            l2 = $urandom_range(15, 0);
            send(k, l, l2, $urandom());
        end
        s_tvalid <= 1'b0;
        drain = 1;
        do @(posedge i_clk); while (pending != 0);
        repeat (600) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ pooled_linked_list_manager.f @@
rtl/core/pllm_pkg.sv
rtl/core/pllm_ram.sv
rtl/core/pooled_linked_list_manager.sv
verif/pooled_linked_list_manager_checker.sv
verif/pooled_linked_list_manager_test.sv
